### src/spfd_pkg.sv
// Shared types and constants of the serial panel frame decoder.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package spfd_pkg;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_KEY       = 2'd0;
   localparam kind_type KIND_HEARTBEAT = 2'd1;
   localparam kind_type KIND_TEMP      = 2'd2;
   localparam kind_type KIND_ERROR     = 2'd3;

   localparam logic [7:0] SYNC_FIRST     = 8'hAA;
   localparam logic [7:0] SYNC_SECOND    = 8'h55;
   localparam logic [7:0] SENSOR_MARK    = 8'h00;
   localparam logic [7:0] TYPE_KEY       = 8'h01;
   localparam logic [7:0] TYPE_HEARTBEAT = 8'h02;

   typedef struct packed {
      logic               valid;
      kind_type           kind;
      logic [7:0]         key_code;
      logic signed [15:0] temperature;
   } result_type;

endpackage

`default_nettype wire

### src/serial_panel_frame_decoder.sv
// Top level of the serial panel frame decoder: input register, parser and result register.
// Depends on spfd_pkg and spfd_parser.
`default_nettype none

// One received serial byte enters per beat, and a new beat can be taken every cycle
// while the result register is free. Each byte waits in the input register; the parser
// consumes it from there, and a frame's result is registered in the result register.
// Throughput is one byte per cycle, set by the single pass of the parser state machine;
// it only slows when the rsp side holds off. Only the checksum byte of a good or bad
// frame produces a result beat. Write csr_wdata (0 key panel, 1 temperature sensor)
// only while idle; a write restarts the sync hunt.
module serial_panel_frame_decoder (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_we,
   input  wire         csr_wdata,   // frame_mode
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] key_code, [23:8] temperature
   output logic [1:0]  rsp_tuser    // [1:0] frame_kind
);

   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic                 out_valid_ff;
   spfd_pkg::kind_type   out_kind_ff;
   logic [7:0]           out_key_ff;
   logic signed [15:0]   out_temp_ff;
   logic                 out_free;
   logic                 step;
   spfd_pkg::result_type result;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   spfd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .step      (step),
      .rx_byte   (in_byte_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            out_valid_ff <= result.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
      if (out_free && result.valid) begin
         out_kind_ff <= result.kind;
         out_key_ff  <= result.key_code;
         out_temp_ff <= result.temperature;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_temp_ff, out_key_ff};
   assign rsp_tuser  = out_kind_ff;

`ifndef SYNTH
   a_reset_clears_out: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");
   a_held_byte_stable: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("stalled input byte lost");
   a_key_only_on_key: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != spfd_pkg::KIND_KEY) |-> (rsp_tdata[7:0] == 8'd0))
      else $error("key code on non-key result");
   a_temp_only_on_temp: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != spfd_pkg::KIND_TEMP) |-> (rsp_tdata[23:8] == 16'd0))
      else $error("temperature on non-temperature result");
`endif

endmodule

`default_nettype wire

### src/spfd_parser.sv
// Frame parse state machine: sync hunt, type check, payload capture and checksum test.
// Depends on spfd_pkg for codes and the result struct.
`default_nettype none

module spfd_parser (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    csr_we,
   input  wire                    csr_wdata,
   input  wire                    step,
   input  wire  [7:0]             rx_byte,
   output spfd_pkg::result_type   result
);

   localparam logic [2:0] PH_HUNT    = 3'd0;
   localparam logic [2:0] PH_SYNC2   = 3'd1;
   localparam logic [2:0] PH_TYPE    = 3'd2;
   localparam logic [2:0] PH_PAYLOAD = 3'd3;
   localparam logic [2:0] PH_CHECK   = 3'd4;

   logic       mode_ff;
   logic [2:0] phase_ff, phase_in;
   logic [1:0] index_ff, index_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] type_ff, type_in;
   logic [7:0] held_ff, held_in;

   always_comb begin
      phase_in = phase_ff;
      index_in = index_ff;
      sum_in   = sum_ff;
      type_in  = type_ff;
      held_in  = held_ff;
      result   = '0;
      if (step) begin
         case (phase_ff)
            PH_HUNT: begin
               index_in = 2'd0;
               type_in  = 8'd0;
               held_in  = 8'd0;
               phase_in = (rx_byte == spfd_pkg::SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
               sum_in   = (rx_byte == spfd_pkg::SYNC_FIRST) ? spfd_pkg::SYNC_FIRST : 8'd0;
            end
            PH_SYNC2: begin
               if (rx_byte == spfd_pkg::SYNC_SECOND) begin
                  sum_in   = sum_ff + rx_byte;
                  phase_in = PH_TYPE;
               end else begin
                  index_in = 2'd0;
                  type_in  = 8'd0;
                  held_in  = 8'd0;
                  phase_in = (rx_byte == spfd_pkg::SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
                  sum_in   = (rx_byte == spfd_pkg::SYNC_FIRST) ? spfd_pkg::SYNC_FIRST : 8'd0;
               end
            end
            PH_TYPE: begin
               if (mode_ff && rx_byte == spfd_pkg::SENSOR_MARK) begin
                  phase_in = PH_PAYLOAD;
                  index_in = 2'd0;
               end else if (!mode_ff && rx_byte == spfd_pkg::TYPE_KEY) begin
                  type_in  = rx_byte;
                  sum_in   = sum_ff + rx_byte;
                  phase_in = PH_PAYLOAD;
                  index_in = 2'd0;
               end else if (!mode_ff && rx_byte == spfd_pkg::TYPE_HEARTBEAT) begin
                  type_in  = rx_byte;
                  sum_in   = sum_ff + rx_byte;
                  phase_in = PH_CHECK;
               end else begin
                  index_in = 2'd0;
                  type_in  = 8'd0;
                  held_in  = 8'd0;
                  phase_in = (rx_byte == spfd_pkg::SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
                  sum_in   = (rx_byte == spfd_pkg::SYNC_FIRST) ? spfd_pkg::SYNC_FIRST : 8'd0;
               end
            end
            PH_PAYLOAD: begin
               sum_in = sum_ff + rx_byte;
               if (mode_ff && index_ff == 2'd0) begin
                  type_in  = rx_byte;
                  index_in = 2'd1;
               end else begin
                  held_in  = rx_byte;
                  index_in = mode_ff ? 2'd2 : 2'd1;
                  phase_in = PH_CHECK;
               end
            end
            PH_CHECK: begin
               result.valid = 1'b1;
               if (rx_byte != sum_ff) begin
                  result.kind = spfd_pkg::KIND_ERROR;
               end else if (mode_ff) begin
                  result.kind        = spfd_pkg::KIND_TEMP;
                  result.temperature = {type_ff, held_ff};
               end else if (type_ff == spfd_pkg::TYPE_KEY) begin
                  result.kind     = spfd_pkg::KIND_KEY;
                  result.key_code = held_ff;
               end else begin
                  result.kind = spfd_pkg::KIND_HEARTBEAT;
               end
               phase_in = PH_HUNT;
               index_in = 2'd0;
               sum_in   = 8'd0;
               type_in  = 8'd0;
               held_in  = 8'd0;
            end
            default: begin
               phase_in = PH_HUNT;
               index_in = 2'd0;
               sum_in   = 8'd0;
               type_in  = 8'd0;
               held_in  = 8'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         phase_ff <= PH_HUNT;
         index_ff <= 2'd0;
         sum_ff   <= 8'd0;
         type_ff  <= 8'd0;
         held_ff  <= 8'd0;
      end else if (csr_we) begin
         mode_ff  <= csr_wdata;
         phase_ff <= PH_HUNT;
         index_ff <= 2'd0;
         sum_ff   <= 8'd0;
         type_ff  <= 8'd0;
         held_ff  <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         index_ff <= index_in;
         sum_ff   <= sum_in;
         type_ff  <= type_in;
         held_ff  <= held_in;
      end
   end

endmodule

`default_nettype wire

### test/serial_panel_frame_decoder_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for serial_panel_frame_decoder: a directed table of serial bytes, then
// random frames under several idle and stall mixes; each beat is checked against the
// table's expected result or a built-in parser. Depends on spfd_pkg and the decoder RTL.

module serial_panel_frame_decoder_tb;

   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam int HALF_PHASE    = 168;
   localparam int NUM_ROWS      = 28;
   localparam int IDLE_PCT [0:3]  = '{0, 47, 0, 8};
   localparam int STALL_PCT [0:3] = '{0, 0, 47, 8};

   localparam logic [2:0] PH_HUNT  = 3'd0;
   localparam logic [2:0] PH_SYNC2 = 3'd1;
   localparam logic [2:0] PH_TYPE  = 3'd2;
   localparam logic [2:0] PH_BODY  = 3'd3;
   localparam logic [2:0] PH_CHECK = 3'd4;

   typedef struct packed {
      spfd_pkg::kind_type kind;
      logic [7:0]         key_code;
      logic signed [15:0] temperature;
   } frame_result_type;

   typedef enum logic {ROW_BYTE, ROW_MODE} row_op_type;

   typedef struct packed {
      row_op_type       op;
      logic [7:0]       data;
      logic             typed;
      frame_result_type want;
   } stim_row_type;

   localparam frame_result_type NO_RESULT = '0;

   localparam stim_row_type DIRECTED_ROWS [0:NUM_ROWS-1] = '{
      '{ROW_MODE, 8'h00, 1'b0, NO_RESULT},
      '{ROW_BYTE, 8'hAA, 1'b0, NO_RESULT},
      '{ROW_BYTE, 8'hAA, 1'b0, NO_RESULT},
      '{ROW_BYTE, 8'h55, 1'b0, NO_RESULT},
      '{ROW_BYTE, 8'hAA, 1'b0, NO_RESULT},
      '{ROW_BYTE, 8'h55, 1'b0, NO_RESULT},
      '{ROW_BYTE, 8'h01, 1'b0, NO_RESULT},
      '{ROW_BYTE, 8'hFF, 1'b0, NO_RESULT},
      '{ROW_BYTE, 8'hFF, 1'b1, '{spfd_pkg::KIND_KEY, 8'hFF, 16'sh0000}},
      '{ROW_BYTE, 8'hAA, 1'b0, NO_RESULT},
      '{ROW_BYTE, 8'h55, 1'b0, NO_RESULT},
      '{ROW_BYTE, 8'h02, 1'b0, NO_RESULT},
      '{ROW_BYTE, 8'h01, 1'b1, '{spfd_pkg::KIND_HEARTBEAT, 8'h00, 16'sh0000}},
      '{ROW_MODE, 8'h01, 1'b0, NO_RESULT},
      '{ROW_BYTE, 8'hAA, 1'b0, NO_RESULT},
      '{ROW_BYTE, 8'h55, 1'b0, NO_RESULT},
      '{ROW_BYTE, 8'h00, 1'b0, NO_RESULT},
      '{ROW_BYTE, 8'h80, 1'b0, NO_RESULT},
      '{ROW_BYTE, 8'h00, 1'b0, NO_RESULT},
      '{ROW_BYTE, 8'h7F, 1'b1, '{spfd_pkg::KIND_TEMP, 8'h00, 16'sh8000}},
      '{ROW_BYTE, 8'hAA, 1'b0, NO_RESULT},
      '{ROW_BYTE, 8'h55, 1'b0, NO_RESULT},
      '{ROW_BYTE, 8'hAA, 1'b0, NO_RESULT},
      '{ROW_BYTE, 8'h55, 1'b0, NO_RESULT},
      '{ROW_BYTE, 8'h00, 1'b0, NO_RESULT},
      '{ROW_BYTE, 8'h7F, 1'b0, NO_RESULT},
      '{ROW_BYTE, 8'hFF, 1'b0, NO_RESULT},
      '{ROW_BYTE, 8'h00, 1'b1, '{spfd_pkg::KIND_ERROR, 8'h00, 16'sh0000}}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic        csr_wdata  = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   frame_result_type pending_frames [$];
   frame_result_type head_frame;
   int               failures     = 0;
   int               bytes_sent   = 0;
   int               quiet_cycles = 0;
   int               idle_pct     = 0;
   int               stall_pct    = 0;

   logic       pred_mode  = 1'b0;
   logic [2:0] pred_phase = PH_HUNT;
   logic [1:0] pred_count = '0;
   logic [7:0] pred_sum   = '0;
   logic [7:0] pred_hi    = '0;
   logic [7:0] pred_lo    = '0;

   serial_panel_frame_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void clear_hunt();
      pred_phase = PH_HUNT;
      pred_count = '0;
      pred_sum   = '0;
      pred_hi    = '0;
      pred_lo    = '0;
   endfunction

   function automatic void hunt_from(input logic [7:0] b);
      clear_hunt();
      if (b == spfd_pkg::SYNC_FIRST) begin
         pred_phase = PH_SYNC2;
         pred_sum   = spfd_pkg::SYNC_FIRST;
      end
   endfunction

   // In panel mode pred_hi keeps the type byte and pred_lo the key code; in sensor mode they
   // keep the high and low temperature bytes.
   function automatic void decode_byte(input logic [7:0] b, output logic got,
                                       output frame_result_type res);
      got = 1'b0;
      res = NO_RESULT;
      case (pred_phase)
         PH_HUNT: hunt_from(b);
         PH_SYNC2: begin
            if (b == spfd_pkg::SYNC_SECOND) begin
               pred_sum   = pred_sum + b;
               pred_phase = PH_TYPE;
            end else begin
               hunt_from(b);
            end
         end
         PH_TYPE: begin
            if (pred_mode) begin
               if (b == spfd_pkg::SENSOR_MARK) begin
                  pred_phase = PH_BODY;
                  pred_count = 2'd0;
               end else begin
                  hunt_from(b);
               end
            end else if (b == spfd_pkg::TYPE_KEY) begin
               pred_hi    = b;
               pred_sum   = pred_sum + b;
               pred_phase = PH_BODY;
               pred_count = 2'd0;
            end else if (b == spfd_pkg::TYPE_HEARTBEAT) begin
               pred_hi    = b;
               pred_sum   = pred_sum + b;
               pred_phase = PH_CHECK;
            end else begin
               hunt_from(b);
            end
         end
         PH_BODY: begin
            pred_sum = pred_sum + b;
            if (pred_mode && pred_count == 2'd0) begin
               pred_hi    = b;
               pred_count = 2'd1;
            end else begin
               pred_lo    = b;
               pred_count = pred_count + 2'd1;
               pred_phase = PH_CHECK;
            end
         end
         PH_CHECK: begin
            got = 1'b1;
            if (b != pred_sum) begin
               res.kind = spfd_pkg::KIND_ERROR;
            end else if (pred_mode) begin
               res.kind        = spfd_pkg::KIND_TEMP;
               res.temperature = {pred_hi, pred_lo};
            end else if (pred_hi == spfd_pkg::TYPE_KEY) begin
               res.kind     = spfd_pkg::KIND_KEY;
               res.key_code = pred_lo;
            end else begin
               res.kind = spfd_pkg::KIND_HEARTBEAT;
            end
            clear_hunt();
         end
         default: clear_hunt();
      endcase
   endfunction

   function automatic void note_failure(input string msg);
      failures++;
      if (failures <= 10) begin
         $display("mismatch: %s", msg);
      end
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic typed,
                            input frame_result_type want);
      logic             got;
      frame_result_type res;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decode_byte(b, got, res);
      bytes_sent++;
      if (typed) begin
         pending_frames.push_back(want);
      end else if (got) begin
         pending_frames.push_back(res);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_mode(input logic mode);
      drain();
      csr_wdata <= mode;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
      pred_mode = mode;
      clear_hunt();
   endtask

   // Mostly whole frames of the current mode, some with a bad checksum, the rest cut short
   // with a random byte at the cut, or plain line noise.
   task automatic send_random_frame();
      logic [7:0] fb [0:5];
      logic [7:0] sum;
      int         len;
      int         cut;
      int         pick;
      pick  = $urandom_range(0, 99);
      fb[0] = spfd_pkg::SYNC_FIRST;
      fb[1] = spfd_pkg::SYNC_SECOND;
      if (pred_mode) begin
         fb[2] = spfd_pkg::SENSOR_MARK;
         fb[3] = 8'($urandom_range(0, 255));
         fb[4] = 8'($urandom_range(0, 255));
         len   = 6;
      end else if ($urandom_range(0, 2) != 0) begin
         fb[2] = spfd_pkg::TYPE_KEY;
         fb[3] = 8'($urandom_range(0, 255));
         len   = 5;
      end else begin
         fb[2] = spfd_pkg::TYPE_HEARTBEAT;
         len   = 4;
      end
      sum = 8'h00;
      for (int i = 0; i < len - 1; i++) sum = sum + fb[i];
      fb[len-1] = sum;
      if ($urandom_range(0, 6) == 0) begin
         fb[len-1] = sum ^ 8'($urandom_range(1, 255));
      end
      if (pick < 72) begin
         for (int i = 0; i < len; i++) send_byte(fb[i], 1'b0, NO_RESULT);
      end else if (pick < 88) begin
         cut     = $urandom_range(1, len - 1);
         fb[cut] = 8'($urandom_range(0, 255));
         for (int i = 0; i <= cut; i++) send_byte(fb[i], 1'b0, NO_RESULT);
      end else begin
         repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 3) == 0) begin
               send_byte(spfd_pkg::SYNC_FIRST, 1'b0, NO_RESULT);
            end else begin
               send_byte(8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_frames.size() == 0) begin
            note_failure($sformatf("unexpected beat kind %0d key %02h temp %0d",
                                   rsp_tuser, rsp_tdata[7:0], $signed(rsp_tdata[23:8])));
         end else begin
            head_frame = pending_frames.pop_front();
            if (rsp_tuser !== head_frame.kind || rsp_tdata[7:0] !== head_frame.key_code ||
                rsp_tdata[23:8] !== head_frame.temperature) begin
               note_failure($sformatf(
                  "expected kind %0d key %02h temp %0d, got kind %0d key %02h temp %0d",
                  head_frame.kind, head_frame.key_code, head_frame.temperature,
                  rsp_tuser, rsp_tdata[7:0], $signed(rsp_tdata[23:8])));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int start_count;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int r = 0; r < NUM_ROWS; r++) begin
         if (DIRECTED_ROWS[r].op == ROW_MODE) begin
            set_mode(DIRECTED_ROWS[r].data[0]);
         end else begin
            send_byte(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
         end
      end
      for (int p = 0; p < 4; p++) begin
         idle_pct  = IDLE_PCT[p];
         stall_pct = STALL_PCT[p];
         set_mode(p[0]);
         start_count = bytes_sent;
         while (bytes_sent - start_count < HALF_PHASE) send_random_frame();
         // The write may land in the middle of a frame, which must restart the hunt.
         set_mode(1'($urandom_range(0, 1)));
         start_count = bytes_sent;
         while (bytes_sent - start_count < HALF_PHASE) send_random_frame();
      end
      drain();
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### files.f
src/spfd_pkg.sv
src/spfd_parser.sv
src/serial_panel_frame_decoder.sv
test/serial_panel_frame_decoder_tb.sv
